>>> src/i2cram_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_pkg: shared types and constants
// Phase codes, function codes, configuration indexes and the item/result
// structs used by the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  // bus phase of the bit-level sequencer
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_TX,
    PH_ACKL,
    PH_ACKH,
    PH_RX,
    PH_MACK,
    PH_STOP
  } phase_t;

  // function codes carried with each tick
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_ACK_TIMEOUT    = 1'b1;

  // reset values of the configuration registers
  localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd42;
  localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd100;

  // last tick of an eight-bit byte, two ticks per bit
  localparam logic [3:0] BYTE_LAST_TICK = 4'd15;

  // byte slots of a transaction
  localparam logic [1:0] SLOT_ADDR  = 2'd0;
  localparam logic [1:0] SLOT_REG   = 2'd1;
  localparam logic [1:0] SLOT_THIRD = 2'd2;
  localparam logic [1:0] SLOT_LSB   = 2'd3;

  // one input tick
  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  reg_address;
    logic [15:0] write_data;
    logic        sda_in;
  } item_t;

  // one result tick
  typedef struct packed {
    logic        scl_level;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [15:0] read_data;
  } res_t;

endpackage

>>> src/i2cram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cram_core: bit-level I2C sequencer
// Holds the transaction state and turns one tick into SCL/SDA levels and
// status; state advances only when the tick is handed to the output register.
// ----------------------------------------------------------------------------
module i2cram_core
  import i2cram_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  item_t      item,
  input  logic [6:0] device_address,
  input  logic [7:0] ack_timeout,
  output res_t       res
);

  // state registers
  phase_t      phase;
  logic [3:0]  bit_count;
  logic [7:0]  shift_byte;
  logic [1:0]  byte_index;
  logic [7:0]  wait_count;
  logic        is_read;
  logic        failed;
  logic [7:0]  held_register;
  logic [15:0] held_data;

  phase_t      phase_next;
  logic [3:0]  bit_count_next;
  logic [7:0]  shift_byte_next;
  logic [1:0]  byte_index_next;
  logic [7:0]  wait_count_next;
  logic        is_read_next;
  logic        failed_next;
  logic [7:0]  held_register_next;
  logic [15:0] held_data_next;

  // state as seen by this tick, after a possible transaction start
  phase_t      e_phase;
  logic [3:0]  e_bit_count;
  logic [1:0]  e_byte_index;
  logic [7:0]  e_wait_count;
  logic        e_is_read;
  logic        e_failed;
  logic [7:0]  e_held_register;
  logic [15:0] e_held_data;
  logic        start_req;
  logic [8:0]  wait_inc;

  // byte sent in a given slot
  function automatic logic [7:0] byte_sel(
    input logic [1:0]  slot,
    input logic        rd,
    input logic [6:0]  addr,
    input logic [7:0]  regv,
    input logic [15:0] data
  );
    logic [7:0] b;
    case (slot)
      SLOT_ADDR:  b = {addr, 1'b0};
      SLOT_REG:   b = regv;
      SLOT_THIRD: b = rd ? {addr, 1'b1} : data[15:8];
      default:    b = data[7:0];
    endcase
    return b;
  endfunction

  // transaction start on an idle tick
  always_comb begin
    start_req = (phase == PH_IDLE) &&
                (item.func == FUNC_WRITE || item.func == FUNC_READ);
    if (start_req) begin
      e_phase         = PH_START;
      e_bit_count     = '0;
      e_byte_index    = SLOT_ADDR;
      e_wait_count    = '0;
      e_is_read       = (item.func == FUNC_READ);
      e_failed        = 1'b0;
      e_held_register = item.reg_address;
      e_held_data     = (item.func == FUNC_READ) ? 16'd0 : item.write_data;
    end else begin
      e_phase         = phase;
      e_bit_count     = bit_count;
      e_byte_index    = byte_index;
      e_wait_count    = wait_count;
      e_is_read       = is_read;
      e_failed        = failed;
      e_held_register = held_register;
      e_held_data     = held_data;
    end
    wait_inc = {1'b0, e_wait_count} + 9'd1;
  end

  // next state
  always_comb begin
    phase_next         = e_phase;
    bit_count_next     = e_bit_count;
    shift_byte_next    = shift_byte;
    byte_index_next    = e_byte_index;
    wait_count_next    = e_wait_count;
    is_read_next       = e_is_read;
    failed_next        = e_failed;
    held_register_next = e_held_register;
    held_data_next     = e_held_data;
    unique case (e_phase)
      PH_START: begin
        if (e_bit_count == 4'd0) begin
          bit_count_next = 4'd1;
        end else if (e_bit_count == 4'd1) begin
          bit_count_next = 4'd2;
        end else begin
          shift_byte_next = byte_sel(e_byte_index, e_is_read, device_address,
                                     e_held_register, e_held_data);
          bit_count_next  = '0;
          phase_next      = PH_TX;
        end
      end
      PH_TX: begin
        if (e_bit_count[0]) begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
        end
        if (e_bit_count == BYTE_LAST_TICK) begin
          phase_next      = PH_ACKL;
          wait_count_next = '0;
        end else begin
          bit_count_next = e_bit_count + 4'd1;
        end
      end
      PH_ACKL: begin
        phase_next = PH_ACKH;
      end
      PH_ACKH: begin
        if (!item.sda_in) begin
          // acknowledged: pick the next step of the transaction
          if (!e_is_read) begin
            if (e_byte_index != SLOT_LSB) begin
              byte_index_next = e_byte_index + 2'd1;
              shift_byte_next = byte_sel(e_byte_index + 2'd1, e_is_read,
                                         device_address, e_held_register,
                                         e_held_data);
              bit_count_next  = '0;
              phase_next      = PH_TX;
            end else begin
              phase_next     = PH_STOP;
              bit_count_next = '0;
            end
          end else if (e_byte_index == SLOT_ADDR) begin
            byte_index_next = SLOT_REG;
            shift_byte_next = byte_sel(SLOT_REG, e_is_read, device_address,
                                       e_held_register, e_held_data);
            bit_count_next  = '0;
            phase_next      = PH_TX;
          end else if (e_byte_index == SLOT_REG) begin
            byte_index_next = SLOT_THIRD;
            phase_next      = PH_START;
            bit_count_next  = '0;
          end else begin
            byte_index_next = SLOT_THIRD;
            phase_next      = PH_RX;
            bit_count_next  = '0;
          end
        end else if (wait_inc > {1'b0, ack_timeout}) begin
          failed_next    = 1'b1;
          phase_next     = PH_STOP;
          bit_count_next = '0;
        end else begin
          wait_count_next = wait_inc[7:0];
        end
      end
      PH_RX: begin
        if (e_bit_count[0]) begin
          held_data_next = {e_held_data[14:0], item.sda_in};
        end
        if (e_bit_count == BYTE_LAST_TICK) begin
          phase_next     = PH_MACK;
          bit_count_next = '0;
        end else begin
          bit_count_next = e_bit_count + 4'd1;
        end
      end
      PH_MACK: begin
        if (e_bit_count == 4'd0) begin
          bit_count_next = 4'd1;
        end else if (e_byte_index == SLOT_THIRD) begin
          byte_index_next = SLOT_LSB;
          phase_next      = PH_RX;
          bit_count_next  = '0;
        end else begin
          phase_next     = PH_STOP;
          bit_count_next = '0;
        end
      end
      PH_STOP: begin
        if (e_bit_count == 4'd0) begin
          bit_count_next = 4'd1;
        end else if (e_bit_count == 4'd1) begin
          bit_count_next = 4'd2;
        end else begin
          phase_next     = PH_IDLE;
          bit_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // line levels and status for this tick
  always_comb begin
    res = '{scl_level: 1'b1, sda_release: 1'b1, busy_res: 1'b1,
            done_res: 1'b0, status: 1'b0, read_data: 16'd0};
    unique case (e_phase)
      PH_START: begin
        res.scl_level   = (e_bit_count != 4'd0);
        res.sda_release = (e_bit_count == 4'd0) || (e_bit_count == 4'd1);
      end
      PH_TX: begin
        res.scl_level   = e_bit_count[0];
        res.sda_release = shift_byte[7];
      end
      PH_ACKL: begin
        res.scl_level = 1'b0;
      end
      PH_ACKH: begin
        res.scl_level = 1'b1;
      end
      PH_RX: begin
        res.scl_level = e_bit_count[0];
      end
      PH_MACK: begin
        res.scl_level   = e_bit_count[0];
        res.sda_release = (e_byte_index != SLOT_THIRD);
      end
      PH_STOP: begin
        if (e_bit_count == 4'd0) begin
          res.scl_level   = 1'b0;
          res.sda_release = 1'b0;
        end else if (e_bit_count == 4'd1) begin
          res.sda_release = 1'b0;
        end else begin
          res.done_res  = 1'b1;
          res.status    = e_failed;
          res.read_data = (e_is_read && !e_failed) ? e_held_data : 16'd0;
        end
      end
      default: begin
        res.busy_res = 1'b0;
      end
    endcase
  end

  // state update when the tick moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_byte    <= '0;
      byte_index    <= '0;
      wait_count    <= '0;
      is_read       <= 1'b0;
      failed        <= 1'b0;
      held_register <= '0;
      held_data     <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      byte_index    <= byte_index_next;
      wait_count    <= wait_count_next;
      is_read       <= is_read_next;
      failed        <= failed_next;
      held_register <= held_register_next;
      held_data     <= held_data_next;
    end
  end

endmodule

>>> src/i2c_register_access_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_access_master_top: I2C master for 16-bit register access
// Each input transaction is one SCL half-period tick; each output
// transaction gives the SCL/SDA levels to drive and the transfer status.
//
// Usage:
//   s_axis carries one tick: tuser holds the function code (plain tick,
//   start register write, start register read), tdata the register
//   address, write data and sampled SDA. A start code is honored only
//   while no transfer is running.
//   m_axis returns exactly one result per tick; tlast marks the final
//   stop tick of a transfer, where status and read data are valid.
//   cfg writes the device address (index 0) and acknowledge timeout
//   (index 1); it is always ready. The user must write it only while the block is idle;
//   the block itself does not enforce this. A tick passes through the input
//   register feeding the sequencer and the result register behind it; one
//   tick is taken per cycle while the receiver does not stall.
//   Reset clears the sequencer to idle, empties both registers and loads
//   device address 42 and timeout 100. A stalled receiver holds the result
//   register; the input register then holds, and s_axis_tready drops.
// ----------------------------------------------------------------------------
module i2c_register_access_master_top
  import i2cram_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // reg_address[7:0], write_data[23:8], sda_in[24]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // scl_level[0], sda_release[1], busy_res[2],
                                      // status[3], read_data[19:4]
  output logic        m_axis_tlast,   // done_res
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  res_t       out_res;
  res_t       core_res;
  logic       advance;
  logic [6:0] device_address;
  logic [7:0] ack_timeout;

  // pipeline flow
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= '{func: s_axis_tuser, reg_address: s_axis_tdata[7:0],
                   write_data: s_axis_tdata[23:8], sda_in: s_axis_tdata[24]};
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= DEVICE_ADDRESS_RESET;
      ack_timeout    <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        CFG_ACK_TIMEOUT:    ack_timeout    <= cfg_data;
        default:            ;
      endcase
    end
  end

  i2cram_core u_core (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .item           (in_item),
    .device_address (device_address),
    .ack_timeout    (ack_timeout),
    .res            (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.done_res;
  assign m_axis_tdata  = {4'd0, out_res.read_data, out_res.status, out_res.busy_res,
                          out_res.sda_release, out_res.scl_level};

  // a finished transfer is always reported as busy on its last tick
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.done_res |-> out_res.busy_res)
    else $error("done without busy");

  // status and read data appear only on the finishing tick
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_res.status || out_res.read_data != 16'd0) |-> out_res.done_res)
    else $error("status or read data outside done tick");

  // a failed transfer never returns data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status |-> out_res.read_data == 16'd0)
    else $error("read data on failed transfer");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_valid)
    else $error("pipeline not empty after reset");

endmodule

>>> dv/tb_i2c_register_access_master_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_register_access_master_top: self-checking bench for the I2C master
// Feeds SCL half-period ticks through s_axis and compares every m_axis
// result with an in-bench bus model. A short directed table covers idle
// ticks, the unused function code, starts while busy and missing acknowledges
// at zero timeout. Random phases then run register writes and reads with
// acknowledge delays, dropped acknowledges and random read bits, each phase
// under a new device address and timeout. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_i2c_register_access_master_top;
  import i2cram_pkg::*;

  // function code with no meaning, taken as a plain tick
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // results that follow directly from the bus protocol
  localparam res_t BUS_IDLE_RES  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000};
  localparam res_t START_RES     = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000};
  localparam res_t NACK_DONE_RES = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0000};

  typedef struct {
    bit         is_cfg;
    logic       cfg_sel;
    logic [7:0] cfg_val;
    item_t      tick;
    int         reps;
    bit         fixed;
    res_t       want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = FUNC_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_DEVICE_ADDRESS;
  logic [7:0]  cfg_data = '0;

  // bus model state
  phase_t      bus_phase;
  logic [3:0]  tick_cnt;
  logic [7:0]  tx_shift;
  logic [1:0]  slot;
  logic [7:0]  ack_wait;
  logic        op_read;
  logic [7:0]  hold_reg;
  logic [15:0] hold_data;
  logic        ack_missing;
  logic [6:0]  dev_addr;
  logic [7:0]  ack_limit;

  res_t        bus_levels_due [$];
  int          mismatches = 0;
  bit          steady = 1'b0;
  int          hold_cnt = 0;

  // random transaction plan: drop the acknowledge of one byte slot
  bit          fail_plan = 1'b0;
  logic [1:0]  fail_slot = SLOT_ADDR;

  plan_row_t   plan [13];

  i2c_register_access_master_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // mostly no gap, some short ones, a few long ones
  function automatic int idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // load the next byte of the transfer into the shifter
  task automatic load_byte();
    case (slot)
      SLOT_ADDR: tx_shift = {dev_addr, 1'b0};
      SLOT_REG:  tx_shift = hold_reg;
      SLOT_THIRD: tx_shift = op_read ? {dev_addr, 1'b1} : hold_data[15:8];
      default:   tx_shift = hold_data[7:0];
    endcase
    tick_cnt = '0;
    bus_phase = PH_TX;
  endtask

  task automatic enter_stop();
    bus_phase = PH_STOP;
    tick_cnt = '0;
  endtask

  // bus levels and status for one accepted tick
  task automatic predict_bus_tick(input item_t tk, output res_t r);
    logic [8:0] polls;
    r = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 16'h0000};
    if (bus_phase == PH_IDLE && (tk.func == FUNC_WRITE || tk.func == FUNC_READ)) begin
      op_read = (tk.func == FUNC_READ);
      hold_reg = tk.reg_address;
      hold_data = op_read ? 16'h0000 : tk.write_data;
      slot = SLOT_ADDR;
      ack_wait = '0;
      ack_missing = 1'b0;
      bus_phase = PH_START;
      tick_cnt = '0;
    end
    case (bus_phase)
      PH_START: begin
        r.scl_level = (tick_cnt != 0);
        r.sda_release = (tick_cnt < 2);
        if (tick_cnt < 2) tick_cnt = tick_cnt + 4'd1;
        else load_byte();
      end
      PH_TX: begin
        r.scl_level = tick_cnt[0];
        r.sda_release = tx_shift[7];
        if (tick_cnt[0]) tx_shift = tx_shift << 1;
        if (tick_cnt >= BYTE_LAST_TICK) begin
          bus_phase = PH_ACKL;
          ack_wait = '0;
        end else begin
          tick_cnt = tick_cnt + 4'd1;
        end
      end
      PH_ACKL: begin
        r.scl_level = 1'b0;
        bus_phase = PH_ACKH;
      end
      PH_ACKH: begin
        if (!tk.sda_in) begin
          // acknowledged: move on to the next byte, repeated start or read
          if (!op_read) begin
            if (slot != SLOT_LSB) begin
              slot = slot + 2'd1;
              load_byte();
            end else begin
              enter_stop();
            end
          end else if (slot == SLOT_ADDR) begin
            slot = SLOT_REG;
            load_byte();
          end else if (slot == SLOT_REG) begin
            slot = SLOT_THIRD;
            bus_phase = PH_START;
            tick_cnt = '0;
          end else begin
            slot = SLOT_THIRD;
            bus_phase = PH_RX;
            tick_cnt = '0;
          end
        end else begin
          polls = {1'b0, ack_wait} + 9'd1;
          if (polls > {1'b0, ack_limit}) begin
            ack_missing = 1'b1;
            enter_stop();
          end else begin
            ack_wait = polls[7:0];
          end
        end
      end
      PH_RX: begin
        r.scl_level = tick_cnt[0];
        if (tick_cnt[0]) hold_data = {hold_data[14:0], tk.sda_in};
        if (tick_cnt >= BYTE_LAST_TICK) begin
          bus_phase = PH_MACK;
          tick_cnt = '0;
        end else begin
          tick_cnt = tick_cnt + 4'd1;
        end
      end
      PH_MACK: begin
        // ack after the first read byte, nack after the second
        r.scl_level = tick_cnt[0];
        r.sda_release = (slot != SLOT_THIRD);
        if (tick_cnt == 0) begin
          tick_cnt = 4'd1;
        end else if (slot == SLOT_THIRD) begin
          slot = SLOT_LSB;
          bus_phase = PH_RX;
          tick_cnt = '0;
        end else begin
          enter_stop();
        end
      end
      PH_STOP: begin
        r.scl_level = (tick_cnt != 0);
        r.sda_release = (tick_cnt >= 2);
        if (tick_cnt < 2) begin
          tick_cnt = tick_cnt + 4'd1;
        end else begin
          r.done_res = 1'b1;
          r.status = ack_missing;
          r.read_data = (op_read && !ack_missing) ? hold_data : 16'h0000;
          bus_phase = PH_IDLE;
          tick_cnt = '0;
        end
      end
      default: begin
        r.busy_res = 1'b0;
        bus_phase = PH_IDLE;
      end
    endcase
  endtask

  // one input transaction, then record what it must produce
  task automatic send_tick(input item_t tk, input bit fixed, input res_t want);
    int   gap;
    res_t r;
    gap = idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= tk.func;
    s_axis_tdata <= {7'd0, tk.sda_in, tk.write_data, tk.reg_address};
    do @(posedge clk); while (!s_axis_tready);
    predict_bus_tick(tk, r);
    bus_levels_due.push_back(fixed ? want : r);
  endtask

  // stop sending and let the block finish every pending tick
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (bus_levels_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [7:0] val);
    cfg_index <= sel;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == CFG_DEVICE_ADDRESS) dev_addr = val[6:0];
    else ack_limit = val;
    @(posedge clk);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      hold_cnt = idle_len();
    end
  end

  // compare each output transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tlast,
             m_axis_tdata[3], m_axis_tdata[19:4]};
      if (bus_levels_due.size() == 0) begin
        $error("result with no transaction pending");
        mismatches++;
      end else begin
        want = bus_levels_due.pop_front();
        check_field("scl_level", want.scl_level, got.scl_level);
        check_field("sda_release", want.sda_release, got.sda_release);
        check_field("busy_res", want.busy_res, got.busy_res);
        check_field("done_res", want.done_res, got.done_res);
        check_field("status", want.status, got.status);
        check_field("read_data", want.read_data, got.read_data);
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    item_t      tk;
    int         i;
    int         n;
    int         ph;
    int         ph_ticks;
    logic [6:0] addr_tab [6];
    logic [7:0] limit_tab [6];
    logic [7:0] cfg_b;

    // model state after reset
    bus_phase = PH_IDLE;
    tick_cnt = '0;
    tx_shift = '0;
    slot = SLOT_ADDR;
    ack_wait = '0;
    op_read = 1'b0;
    hold_reg = '0;
    hold_data = '0;
    ack_missing = 1'b0;
    dev_addr = DEVICE_ADDRESS_RESET;
    ack_limit = ACK_TIMEOUT_RESET;

    // directed: idle ticks, then a write and a read that lose the first
    // acknowledge at zero timeout, each with a start attempt while busy
    plan[0]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_TICK, 8'h00, 16'h0000, 1'b0}, 1, 1'b1, BUS_IDLE_RES};
    plan[1]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_UNUSED, 8'hFF, 16'hFFFF, 1'b1}, 1, 1'b1, BUS_IDLE_RES};
    plan[2]  = '{1'b1, CFG_ACK_TIMEOUT, 8'h00, '0, 0, 1'b0, BUS_IDLE_RES};
    plan[3]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_WRITE, 8'hFF, 16'hFFFF, 1'b0}, 1, 1'b1, START_RES};
    plan[4]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_READ, 8'h00, 16'h0000, 1'b1}, 1, 1'b0, BUS_IDLE_RES};
    plan[5]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_TICK, 8'h5A, 16'hA5C3, 1'b1}, 21, 1'b0, BUS_IDLE_RES};
    plan[6]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_TICK, 8'h00, 16'h0000, 1'b1}, 1, 1'b1, NACK_DONE_RES};
    plan[7]  = '{1'b1, CFG_DEVICE_ADDRESS, 8'hFF, '0, 0, 1'b0, BUS_IDLE_RES};
    plan[8]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_READ, 8'h00, 16'hFFFF, 1'b1}, 1, 1'b1, START_RES};
    plan[9]  = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_WRITE, 8'hFF, 16'h0000, 1'b0}, 1, 1'b0, BUS_IDLE_RES};
    plan[10] = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_UNUSED, 8'h3C, 16'h0F0F, 1'b1}, 21, 1'b0, BUS_IDLE_RES};
    plan[11] = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_TICK, 8'h00, 16'h0000, 1'b1}, 1, 1'b1, NACK_DONE_RES};
    plan[12] = '{1'b0, CFG_DEVICE_ADDRESS, 8'h00,
                 {FUNC_TICK, 8'h00, 16'h0000, 1'b0}, 1, 1'b1, BUS_IDLE_RES};

    // one setting per random phase, the extremes among them
    addr_tab[0] = 7'd0;
    addr_tab[1] = 7'd127;
    addr_tab[2] = 7'($urandom);
    addr_tab[3] = DEVICE_ADDRESS_RESET;
    addr_tab[4] = 7'($urandom);
    addr_tab[5] = 7'($urandom);
    limit_tab[0] = ACK_TIMEOUT_RESET;
    limit_tab[1] = 8'd1;
    limit_tab[2] = 8'd255;
    limit_tab[3] = 8'd3;
    limit_tab[4] = 8'd8;
    limit_tab[5] = 8'd2;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (i = 0; i < 13; i++) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].cfg_sel, plan[i].cfg_val);
      end else begin
        for (n = 0; n < plan[i].reps; n++)
          send_tick(plan[i].tick, plan[i].fixed, plan[i].want);
      end
    end

    // random phases of whole transfers with random content
    for (ph = 0; ph < 6; ph++) begin
      settle();
      cfg_b = 8'($urandom);
      cfg_b[6:0] = addr_tab[ph];
      write_reg(CFG_DEVICE_ADDRESS, cfg_b);
      write_reg(CFG_ACK_TIMEOUT, limit_tab[ph]);
      steady = (ph % 2 == 1);
      ph_ticks = 0;
      while (ph_ticks < 60 || bus_phase != PH_IDLE) begin
        tk.reg_address = 8'($urandom);
        tk.write_data = 16'($urandom);
        tk.sda_in = 1'($urandom_range(0, 1));
        if (bus_phase == PH_IDLE) begin
          if ($urandom_range(0, 3) == 0) begin
            tk.func = ($urandom_range(0, 1) != 0) ? FUNC_TICK : FUNC_UNUSED;
          end else begin
            tk.func = ($urandom_range(0, 1) != 0) ? FUNC_READ : FUNC_WRITE;
            fail_plan = ($urandom_range(0, 3) == 0);
            fail_slot = 2'($urandom_range(0, (tk.func == FUNC_READ) ? 2 : 3));
          end
        end else begin
          // start codes while busy must be ignored
          tk.func = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : FUNC_TICK;
          if (bus_phase == PH_ACKH) begin
            if (fail_plan && slot == fail_slot) tk.sda_in = 1'b1;
            else if ({1'b0, ack_wait} + 9'd1 > {1'b0, ack_limit}) tk.sda_in = 1'b0;
            else tk.sda_in = ($urandom_range(0, 3) == 0);
          end
        end
        send_tick(tk, 1'b0, BUS_IDLE_RES);
        ph_ticks++;
      end
    end

    settle();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
